// ===== hdl/tgd_pkg.sv =====
// Shared types and constants of the touch gesture detector.
// Used by the interfaces, the front, the back and the top level.
// No dependencies.
package tgd_pkg;

  localparam int NUM_GEST   = 5;
  localparam int GEST_W     = 3;
  localparam int KIND_W     = 2;
  localparam int ELAPSED_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HOLD_W     = 16;
  localparam int DIST_CFG_W = 12;
  localparam int QUEUE_DEPTH = 4;

  // Gesture codes, in emission order
  typedef enum logic [GEST_W-1:0] {
    G_SWIPE  = 3'd0,
    G_HOLD   = 3'd1,
    G_TAP    = 3'd2,
    G_SWIPE2 = 3'd3,
    G_PINCH  = 3'd4
  } gest_e;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESSED  = 2'd0,
    EV_REPEAT   = 2'd1,
    EV_RELEASED = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_TIME  = 2'd0,
    REG_MAX_SWIPE  = 2'd1,
    REG_PINCH_DIST = 2'd2,
    REG_PINCH_MOVE = 2'd3
  } reg_e;

  typedef struct packed {
    logic [HOLD_W-1:0]     hold_time;
    logic [DIST_CFG_W-1:0] max_swipe;
    logic [DIST_CFG_W-1:0] pinch_dist;
    logic [DIST_CFG_W-1:0] pinch_move;
  } cfg_t;

  localparam logic [HOLD_W-1:0]     HOLD_TIME_RST  = 16'd300;
  localparam logic [DIST_CFG_W-1:0] MAX_SWIPE_RST  = 12'd150;
  localparam logic [DIST_CFG_W-1:0] PINCH_DIST_RST = 12'd150;
  localparam logic [DIST_CFG_W-1:0] PINCH_MOVE_RST = 12'd50;

endpackage

// ===== hdl/tgd_if.sv =====
// Handshake channels of the touch gesture detector: touch frames in, events out.
// Depends on tgd_pkg.
interface tgd_frame_if #(
  parameter int COORD_BITS = 12
);
  logic                               valid;
  logic                               ready;
  logic                               first_active;
  logic                               second_active;
  logic [COORD_BITS-1:0]              first_x;
  logic [COORD_BITS-1:0]              first_y;
  logic [COORD_BITS-1:0]              second_x;
  logic [COORD_BITS-1:0]              second_y;
  logic [tgd_pkg::ELAPSED_W-1:0]      elapsed_ms;

  modport source (
    output valid, first_active, second_active, first_x, first_y, second_x, second_y,
           elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, first_active, second_active, first_x, first_y, second_x, second_y,
           elapsed_ms,
    output ready
  );
endinterface

interface tgd_event_if #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic [tgd_pkg::GEST_W-1:0]   gesture;
  logic [tgd_pkg::KIND_W-1:0]   event_kind;
  logic [COORD_BITS-1:0]        pos_a_x;
  logic [COORD_BITS-1:0]        pos_a_y;
  logic [COORD_BITS-1:0]        pos_b_x;
  logic [COORD_BITS-1:0]        pos_b_y;
  logic [TIME_BITS-1:0]         down_ms;
  logic                         last;

  modport source (
    output valid, gesture, event_kind, pos_a_x, pos_a_y, pos_b_x, pos_b_y, down_ms, last,
    input  ready
  );
  modport sink (
    input  valid, gesture, event_kind, pos_a_x, pos_a_y, pos_b_x, pos_b_y, down_ms, last,
    output ready
  );
endinterface

// ===== hdl/touch_gesture_detector.sv =====
// Touch gesture detector: tap, hold and swipe for one finger, swipe and pinch
// for two fingers, reported as pressed, repeat or released events.
// Depends on tgd_pkg, tgd_if, tgd_front, tgd_fifo and tgd_back.
//
// Channels: frame_i takes one touch frame per beat (contact flags, both
// positions, milliseconds since the previous frame). event_o gives zero to
// four events per frame, in gesture order, with last set on the frame's final
// event. Frames that cause no event produce nothing on event_o.
// Throughput: the front pipeline takes a frame every cycle unless it stalls on a full
// queue; the event serializer in the back sends one event per cycle while the receiver
// is ready (one frame per cycle when each carries at most one event).
// A four-entry bundle queue separates front and back; when the receiver stalls,
// the queue fills and then frame_i.ready drops, without losing any event.
// Reset (rst_ni low, asynchronous) clears contact history, anchors, down-times,
// held flags and the queue, and loads the default thresholds. Configuration
// writes (cfg_we_i, cfg_idx_i, cfg_data_i) are taken at once; write only when
// the block is idle.
module touch_gesture_detector #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tgd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tgd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tgd_frame_if.sink                         frame_i,
  tgd_event_if.source                       event_o
);

  localparam int BW = tgd_pkg::NUM_GEST*(1+tgd_pkg::KIND_W) + 6*COORD_BITS + 2*TIME_BITS;

  tgd_pkg::cfg_t cfg_q;
  logic          push_valid, full, pop, empty;
  logic [BW-1:0] push_data, head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time  <= tgd_pkg::HOLD_TIME_RST;
      cfg_q.max_swipe  <= tgd_pkg::MAX_SWIPE_RST;
      cfg_q.pinch_dist <= tgd_pkg::PINCH_DIST_RST;
      cfg_q.pinch_move <= tgd_pkg::PINCH_MOVE_RST;
    end else if (cfg_we_i) begin
      case (tgd_pkg::reg_e'(cfg_idx_i))
        tgd_pkg::REG_HOLD_TIME:  cfg_q.hold_time  <= cfg_data_i[tgd_pkg::HOLD_W-1:0];
        tgd_pkg::REG_MAX_SWIPE:  cfg_q.max_swipe  <= cfg_data_i[tgd_pkg::DIST_CFG_W-1:0];
        tgd_pkg::REG_PINCH_DIST: cfg_q.pinch_dist <= cfg_data_i[tgd_pkg::DIST_CFG_W-1:0];
        tgd_pkg::REG_PINCH_MOVE: cfg_q.pinch_move <= cfg_data_i[tgd_pkg::DIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  tgd_front #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .frame       (frame_i),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(!full)
  );

  tgd_fifo #(
    .WIDTH(BW),
    .DEPTH(tgd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  tgd_back #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .evt    (event_o)
  );

endmodule

// ===== hdl/tgd_front.sv =====
// Front of the gesture detector: three-stage frame pipeline that tracks contacts,
// measures spacing and midpoint drift, and decides each frame's events as a bundle.
// Depends on tgd_pkg and tgd_frame_if.
module tgd_front #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tgd_pkg::cfg_t        cfg_i,
  tgd_frame_if.sink            frame,
  output logic                 push_valid_o,
  output logic [tgd_pkg::NUM_GEST*(1+tgd_pkg::KIND_W)+6*COORD_BITS+2*TIME_BITS-1:0]
                               push_data_o,
  input  logic                 push_ready_i
);

  localparam int C    = COORD_BITS;
  localparam int T    = TIME_BITS;
  localparam int NG   = tgd_pkg::NUM_GEST;
  localparam int EW   = tgd_pkg::ELAPSED_W;
  localparam int DW   = 2*C + 1;                          // squared spacing
  localparam int MW   = 2*C + 3;                          // squared midpoint drift
  localparam int SQW  = 2*tgd_pkg::DIST_CFG_W;            // squared threshold
  localparam int CMPW = (MW > SQW + 2) ? MW : SQW + 2;
  localparam int HW   = (T + 1 > tgd_pkg::HOLD_W + 1) ? T + 1 : tgd_pkg::HOLD_W + 1;

  typedef struct packed {
    logic [NG-1:0]                   mask;
    tgd_pkg::kind_e [NG-1:0]         kind;
    logic [C-1:0]                    a1x;
    logic [C-1:0]                    a1y;
    logic [C-1:0]                    c1x;
    logic [C-1:0]                    c1y;
    logic [C-1:0]                    c2x;
    logic [C-1:0]                    c2y;
    logic [T-1:0]                    opt;
    logic [T-1:0]                    tpt;
  } bnd_t;

  typedef struct packed {
    logic          f;
    logic          s;
    logic [C-1:0]  c1x;
    logic [C-1:0]  c1y;
    logic [C-1:0]  c2x;
    logic [C-1:0]  c2y;
    logic [EW-1:0] el;
    logic [2*C-1:0] sqx;
    logic [2*C-1:0] sqy;
    logic [C:0]    msx;
    logic [C:0]    msy;
  } p1_t;

  typedef struct packed {
    logic            f;
    logic            both;
    logic            pf;        // first contact down in previous frame
    logic            pb;        // both contacts down in previous frame
    logic            op_start;
    logic            tp_start;
    logic [C-1:0]    a1x;
    logic [C-1:0]    a1y;
    logic [C-1:0]    c1x;
    logic [C-1:0]    c1y;
    logic [C-1:0]    c2x;
    logic [C-1:0]    c2y;
    logic [EW-1:0]   el;
    logic [DW-1:0]   dist_sq;
    logic [DW-1:0]   adist;
    logic [2*C+1:0]  mdx2;
    logic [2*C+1:0]  mdy2;
  } p2_t;

  // ---------------- threshold squares, refreshed every cycle
  logic [SQW-1:0]  msw_q, pdt_q;
  logic [SQW+1:0]  mlim_q;
  logic [SQW-1:0]  pms_d;

  assign pms_d = SQW'(cfg_i.pinch_move) * SQW'(cfg_i.pinch_move);

  always_ff @(posedge clk_i) begin
    msw_q  <= SQW'(cfg_i.max_swipe) * SQW'(cfg_i.max_swipe);
    pdt_q  <= SQW'(cfg_i.pinch_dist) * SQW'(cfg_i.pinch_dist);
    mlim_q <= {pms_d, 2'b00};
  end

  // ---------------- pipeline control
  logic p1_valid_q, p2_valid_q;
  logic adv1, adv2;
  p1_t  p1_q, p1_d;
  p2_t  p2_q, p2_d;

  assign adv2        = p2_valid_q && push_ready_i;
  assign adv1        = p1_valid_q && (!p2_valid_q || adv2);
  assign frame.ready = !p1_valid_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      if (frame.ready) p1_valid_q <= frame.valid;
      if (!p2_valid_q || adv2) p2_valid_q <= adv1;
    end
  end

  // ---------------- stage 0: current spacing squares and midpoint sums
  logic [C-1:0] dx0, dy0;

  always_comb begin
    dx0 = (frame.first_x >= frame.second_x) ? frame.first_x - frame.second_x
                                            : frame.second_x - frame.first_x;
    dy0 = (frame.first_y >= frame.second_y) ? frame.first_y - frame.second_y
                                            : frame.second_y - frame.first_y;
    p1_d.f   = frame.first_active;
    p1_d.s   = frame.second_active;
    p1_d.c1x = frame.first_x;
    p1_d.c1y = frame.first_y;
    p1_d.c2x = frame.second_x;
    p1_d.c2y = frame.second_y;
    p1_d.el  = frame.elapsed_ms;
    p1_d.sqx = (2*C)'(dx0) * (2*C)'(dx0);
    p1_d.sqy = (2*C)'(dy0) * (2*C)'(dy0);
    p1_d.msx = (C+1)'(frame.first_x) + (C+1)'(frame.second_x);
    p1_d.msy = (C+1)'(frame.first_y) + (C+1)'(frame.second_y);
  end

  always_ff @(posedge clk_i) begin
    if (frame.valid && frame.ready) p1_q <= p1_d;
  end

  // ---------------- stage 1: contact tracking and anchors
  logic          prev_first_q, prev_both_q;
  logic [C-1:0]  anc_q [4];
  logic [DW-1:0] adist_q;
  logic [C:0]    amsx, amsy, mdx, mdy;

  always_comb begin
    p2_d.f        = p1_q.f;
    p2_d.both     = p1_q.f && p1_q.s;
    p2_d.pf       = prev_first_q;
    p2_d.pb       = prev_both_q;
    p2_d.op_start = p1_q.f && !prev_both_q && !prev_first_q;
    p2_d.tp_start = p2_d.both && !prev_both_q;
    p2_d.a1x      = p2_d.op_start ? p1_q.c1x : anc_q[0];
    p2_d.a1y      = p2_d.op_start ? p1_q.c1y : anc_q[1];
    p2_d.c1x      = p1_q.c1x;
    p2_d.c1y      = p1_q.c1y;
    p2_d.c2x      = p1_q.c2x;
    p2_d.c2y      = p1_q.c2y;
    p2_d.el       = p1_q.el;
    p2_d.dist_sq  = DW'(p1_q.sqx) + DW'(p1_q.sqy);
    p2_d.adist    = p2_d.tp_start ? p2_d.dist_sq : adist_q;
    // midpoint drift in doubled coordinates; zero on a two-point start
    amsx = (C+1)'(p2_d.a1x) + (C+1)'(anc_q[2]);
    amsy = (C+1)'(p2_d.a1y) + (C+1)'(anc_q[3]);
    mdx  = (p1_q.msx >= amsx) ? p1_q.msx - amsx : amsx - p1_q.msx;
    mdy  = (p1_q.msy >= amsy) ? p1_q.msy - amsy : amsy - p1_q.msy;
    if (p2_d.tp_start) begin
      mdx = '0;
      mdy = '0;
    end
    p2_d.mdx2 = (2*C+2)'(mdx) * (2*C+2)'(mdx);
    p2_d.mdy2 = (2*C+2)'(mdy) * (2*C+2)'(mdy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_first_q <= 1'b0;
      prev_both_q  <= 1'b0;
      for (int i = 0; i < 4; i++) anc_q[i] <= '0;
      adist_q      <= '0;
    end else if (adv1) begin
      prev_first_q <= p2_d.f;
      prev_both_q  <= p2_d.both;
      adist_q      <= p2_d.adist;
      if (p2_d.tp_start) begin
        anc_q[0] <= p1_q.c1x;
        anc_q[1] <= p1_q.c1y;
        anc_q[2] <= p1_q.c2x;
        anc_q[3] <= p1_q.c2y;
      end else if (p2_d.op_start) begin
        anc_q[0] <= p1_q.c1x;
        anc_q[1] <= p1_q.c1y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) p2_q <= p2_d;
  end

  // ---------------- stage 2: event decisions, down-times, held flags
  logic [NG-1:0]           held_q, held_d;
  logic [T-1:0]            op_time_q, op_time_d, tp_time_q, tp_time_d;
  logic [DW-1:0]           max_q, max_d;
  logic [T-1:0]            opt_c, tpt_c;
  logic [T:0]              osum, tsum;
  logic [HW-1:0]           hold_w;
  logic [DW-1:0]           mp_c, change, mp_new;
  logic [MW-1:0]           move2;
  logic                    fin3, fin4;
  tgd_pkg::kind_e [NG-1:0] k_c;
  logic [NG-1:0]           v_c, em_c;
  bnd_t                    bnd;

  always_comb begin
    hold_w = HW'(cfg_i.hold_time);
    opt_c  = p2_q.op_start ? '0 : op_time_q;
    tpt_c  = p2_q.tp_start ? '0 : tp_time_q;
    mp_c   = p2_q.tp_start ? '0 : max_q;
    osum   = (T+1)'(opt_c) + (T+1)'(p2_q.el);
    tsum   = (T+1)'(tpt_c) + (T+1)'(p2_q.el);
    change = (p2_q.dist_sq >= p2_q.adist) ? p2_q.dist_sq - p2_q.adist
                                          : p2_q.adist - p2_q.dist_sq;
    mp_new = (change > mp_c) ? change : mp_c;
    move2  = MW'(p2_q.mdx2) + MW'(p2_q.mdy2);
    fin3   = (CMPW'(move2) < CMPW'(mlim_q)) && (CMPW'(mp_new) > CMPW'(pdt_q));
    fin4   = (CMPW'(move2) > CMPW'(mlim_q)) && (CMPW'(mp_new) < CMPW'(pdt_q));

    for (int g = 0; g < NG; g++) k_c[g] = tgd_pkg::EV_PRESSED;
    v_c       = '0;
    op_time_d = op_time_q;
    tp_time_d = tp_time_q;
    max_d     = max_q;

    // one-point gestures; release logic also runs while two fingers stay down
    if (p2_q.f && !p2_q.pb) begin
      if (held_q[tgd_pkg::G_SWIPE]) begin
        k_c[tgd_pkg::G_SWIPE] = tgd_pkg::EV_REPEAT;
        v_c[tgd_pkg::G_SWIPE] = 1'b1;
      end else if (p2_q.a1x != p2_q.c1x || p2_q.a1y != p2_q.c1y) begin
        v_c[tgd_pkg::G_SWIPE] = 1'b1;
      end
      if (HW'(osum) > hold_w && HW'(opt_c) <= hold_w && !held_q[tgd_pkg::G_SWIPE]) begin
        v_c[tgd_pkg::G_HOLD] = 1'b1;
      end
      op_time_d = osum[T] ? {T{1'b1}} : osum[T-1:0];
    end else if (p2_q.pf) begin
      if (HW'(opt_c) < hold_w) begin
        v_c[tgd_pkg::G_TAP] = 1'b1;
      end else if (held_q[tgd_pkg::G_HOLD]) begin
        k_c[tgd_pkg::G_HOLD] = tgd_pkg::EV_RELEASED;
        v_c[tgd_pkg::G_HOLD] = 1'b1;
      end
      if (held_q[tgd_pkg::G_SWIPE]) begin
        k_c[tgd_pkg::G_SWIPE] = tgd_pkg::EV_RELEASED;
        v_c[tgd_pkg::G_SWIPE] = 1'b1;
      end
    end

    // two-point gestures
    if (p2_q.both) begin
      if (p2_q.tp_start) begin
        if (CMPW'(p2_q.dist_sq) < CMPW'(msw_q)) v_c[tgd_pkg::G_SWIPE2] = 1'b1;
        v_c[tgd_pkg::G_PINCH] = 1'b1;
      end
      if (held_q[tgd_pkg::G_SWIPE2]) begin
        k_c[tgd_pkg::G_SWIPE2] = fin3 ? tgd_pkg::EV_RELEASED : tgd_pkg::EV_REPEAT;
        v_c[tgd_pkg::G_SWIPE2] = 1'b1;
      end
      if (held_q[tgd_pkg::G_PINCH]) begin
        k_c[tgd_pkg::G_PINCH] = fin4 ? tgd_pkg::EV_RELEASED : tgd_pkg::EV_REPEAT;
        v_c[tgd_pkg::G_PINCH] = 1'b1;
      end
      tp_time_d = tsum[T] ? {T{1'b1}} : tsum[T-1:0];
      max_d     = mp_new;
    end else if (p2_q.pb) begin
      if (held_q[tgd_pkg::G_SWIPE2]) begin
        k_c[tgd_pkg::G_SWIPE2] = tgd_pkg::EV_RELEASED;
        v_c[tgd_pkg::G_SWIPE2] = 1'b1;
      end
      if (held_q[tgd_pkg::G_PINCH]) begin
        k_c[tgd_pkg::G_PINCH] = tgd_pkg::EV_RELEASED;
        v_c[tgd_pkg::G_PINCH] = 1'b1;
      end
    end

    // at most four events leave; the pinch event drops when all five fire
    em_c = v_c;
    if (&v_c) em_c[tgd_pkg::G_PINCH] = 1'b0;

    // held flags follow the events that leave
    held_d = held_q;
    for (int g = 0; g < NG; g++) begin
      if (em_c[g]) begin
        if (k_c[g] == tgd_pkg::EV_PRESSED) held_d[g] = 1'b1;
        else if (k_c[g] == tgd_pkg::EV_RELEASED) held_d[g] = 1'b0;
      end
    end

    bnd.mask = em_c;
    bnd.kind = k_c;
    bnd.a1x  = p2_q.a1x;
    bnd.a1y  = p2_q.a1y;
    bnd.c1x  = p2_q.c1x;
    bnd.c1y  = p2_q.c1y;
    bnd.c2x  = p2_q.c2x;
    bnd.c2y  = p2_q.c2y;
    bnd.opt  = p2_q.pf && !(p2_q.f && !p2_q.pb) ? op_time_q : opt_c;
    bnd.tpt  = tpt_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      op_time_q <= '0;
      tp_time_q <= '0;
      max_q     <= '0;
    end else if (adv2) begin
      held_q    <= held_d;
      op_time_q <= op_time_d;
      tp_time_q <= tp_time_d;
      max_q     <= max_d;
    end
  end

  assign push_valid_o = adv2 && (|em_c);
  assign push_data_o  = bnd;

endmodule

// ===== hdl/tgd_fifo.sv =====
// Short bundle queue between the front and the back of the gesture detector.
// Flip-flop storage, head visible combinationally. No package dependency.
module tgd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/tgd_back.sv =====
// Back of the gesture detector: takes one frame bundle at a time from the queue
// and sends its events one beat each through a registered output. Depends on tgd_pkg.
module tgd_back #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [tgd_pkg::NUM_GEST*(1+tgd_pkg::KIND_W)+6*COORD_BITS+2*TIME_BITS-1:0]
                      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  tgd_event_if.source evt
);

  localparam int C  = COORD_BITS;
  localparam int T  = TIME_BITS;
  localparam int NG = tgd_pkg::NUM_GEST;

  typedef struct packed {
    logic [NG-1:0]           mask;
    tgd_pkg::kind_e [NG-1:0] kind;
    logic [C-1:0]            a1x;
    logic [C-1:0]            a1y;
    logic [C-1:0]            c1x;
    logic [C-1:0]            c1y;
    logic [C-1:0]            c2x;
    logic [C-1:0]            c2y;
    logic [T-1:0]            opt;
    logic [T-1:0]            tpt;
  } bnd_t;

  bnd_t                   cur_q, head;
  logic [NG-1:0]          rem_q, rem_clr;
  tgd_pkg::gest_e         gi_c;
  logic                   busy, emit;
  logic                   ov_q;
  logic [tgd_pkg::GEST_W-1:0] gest_q;
  tgd_pkg::kind_e         kind_q, kind_c;
  logic [C-1:0]           ax_q, ay_q, bx_q, by_q, ax_c, ay_c, bx_c, by_c;
  logic [T-1:0]           down_q, down_c;
  logic                   last_q;

  assign head = bnd_t'(head_i);
  assign busy = |rem_q;
  assign emit = busy && (!ov_q || evt.ready);

  // lowest pending gesture goes first
  always_comb begin
    gi_c = tgd_pkg::G_SWIPE;
    for (int g = NG - 1; g >= 0; g--) begin
      if (rem_q[g]) gi_c = tgd_pkg::gest_e'(g[tgd_pkg::GEST_W-1:0]);
    end
    rem_clr = rem_q & ~(NG'(1) << gi_c);
  end

  assign pop_o = !empty_i && (!busy || (emit && rem_clr == '0));

  // event fields of the selected gesture
  always_comb begin
    kind_c = cur_q.kind[gi_c];
    case (gi_c)
      tgd_pkg::G_SWIPE, tgd_pkg::G_HOLD, tgd_pkg::G_TAP: begin
        ax_c   = cur_q.a1x;
        ay_c   = cur_q.a1y;
        if (gi_c == tgd_pkg::G_SWIPE && kind_c != tgd_pkg::EV_PRESSED) begin
          ax_c = cur_q.c1x;
          ay_c = cur_q.c1y;
        end
        bx_c   = '0;
        by_c   = '0;
        down_c = cur_q.opt;
      end
      default: begin
        ax_c   = cur_q.c1x;
        ay_c   = cur_q.c1y;
        bx_c   = cur_q.c2x;
        by_c   = cur_q.c2y;
        down_c = cur_q.tpt;
      end
    endcase
  end

  // bundle holding and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (pop_o) rem_q <= head.mask;
      else if (emit) rem_q <= rem_clr;
      if (emit) ov_q <= 1'b1;
      else if (evt.ready) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head;
    if (emit) begin
      gest_q <= gi_c;
      kind_q <= kind_c;
      ax_q   <= ax_c;
      ay_q   <= ay_c;
      bx_q   <= bx_c;
      by_q   <= by_c;
      down_q <= down_c;
      last_q <= (rem_clr == '0);
    end
  end

  assign evt.valid      = ov_q;
  assign evt.gesture    = gest_q;
  assign evt.event_kind = kind_q;
  assign evt.pos_a_x    = ax_q;
  assign evt.pos_a_y    = ay_q;
  assign evt.pos_b_x    = bx_q;
  assign evt.pos_b_y    = by_q;
  assign evt.down_ms    = down_q;
  assign evt.last       = last_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for touch_gesture_detector: random and directed touch frames
// in, events out, checked against an in-bench gesture predictor.
// Depends on tgd_pkg, tgd_if and the detector RTL.
module tb_top;

  localparam int CW           = 12;
  localparam int TW           = 16;
  localparam int TIME_MAX     = (1 << TW) - 1;
  localparam int SETTLE       = 12;     // margin over the detector latency
  localparam int LONG_HOLD    = 90;
  localparam int DRAIN_MAX    = 2000;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    bit                            f;
    bit                            s;
    logic [CW-1:0]                 x1;
    logic [CW-1:0]                 y1;
    logic [CW-1:0]                 x2;
    logic [CW-1:0]                 y2;
    logic [tgd_pkg::ELAPSED_W-1:0] el;
  } frame_t;

  typedef struct {
    tgd_pkg::gest_e gesture;
    tgd_pkg::kind_e kind;
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [CW-1:0]  bx;
    logic [CW-1:0]  by;
    logic [TW-1:0]  down;
    logic           last;
  } ev_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tgd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tgd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tgd_frame_if #(.COORD_BITS(CW))                 frame_bus ();
  tgd_event_if #(.COORD_BITS(CW), .TIME_BITS(TW)) event_bus ();

  touch_gesture_detector #(
    .COORD_BITS(CW),
    .TIME_BITS (TW)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .frame_i   (frame_bus),
    .event_o   (event_bus)
  );

  // Stimulus and scoreboard storage
  frame_t frames_to_send[$];
  ev_t    due_events[$];
  frame_t offered;
  int     n_pushed;
  int     n_accepted;
  int     n_errors;
  int     cycle_cnt;

  // Idle control
  bit src_idle_on;
  bit sink_idle_on;
  bit hold_off_req;
  int hold_left;
  int src_wait;
  int src_run;
  int sink_wait;
  int sink_run;

  // Predictor copy of the registers
  logic [tgd_pkg::HOLD_W-1:0]     cfg_hold_time;
  logic [tgd_pkg::DIST_CFG_W-1:0] cfg_max_swipe;
  logic [tgd_pkg::DIST_CFG_W-1:0] cfg_pinch_dist;
  logic [tgd_pkg::DIST_CFG_W-1:0] cfg_pinch_move;

  // Predictor copy of the gesture state
  bit              had_first;
  bit              had_both;
  bit              two_down;
  int              anchor [4];
  int unsigned     one_ms;
  int unsigned     two_ms;
  longint unsigned peak_change;
  bit              held [tgd_pkg::NUM_GEST];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_error(string msg);
    n_errors++;
    $display("ERROR @%0d: %s", cycle_cnt, msg);
  endtask

  function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned sq_dist(int ax, int ay, int bx, int by);
    longint unsigned dx;
    longint unsigned dy;
    dx = abs_diff(ax, bx);
    dy = abs_diff(ay, by);
    return dx * dx + dy * dy;
  endfunction

  function automatic int unsigned sat_time(int unsigned v);
    return (v > TIME_MAX) ? TIME_MAX : v;
  endfunction

  function automatic ev_t mk_ev(tgd_pkg::kind_e kind, int ax, int ay, int bx, int by,
                                int unsigned down);
    ev_t ev;
    ev.gesture = tgd_pkg::G_SWIPE;
    ev.kind    = kind;
    ev.ax      = CW'(ax);
    ev.ay      = CW'(ay);
    ev.bx      = CW'(bx);
    ev.by      = CW'(by);
    ev.down    = TW'(down);
    ev.last    = 1'b0;
    return ev;
  endfunction

  // Gesture predictor: updates the state for one accepted frame and queues its events
  function automatic void predict_gestures(frame_t fr);
    ev_t             pend [tgd_pkg::NUM_GEST];
    bit              pend_on [tgd_pkg::NUM_GEST];
    ev_t             outs [4];
    bit              both;
    int              x1;
    int              y1;
    int              x2;
    int              y2;
    int unsigned     t_sum;
    longint unsigned sw_lim;
    longint unsigned pd_lim;
    longint unsigned mv_lim;
    longint unsigned mdx;
    longint unsigned mdy;
    longint unsigned mv2;
    longint unsigned chg;
    int              n;
    x1 = fr.x1;
    y1 = fr.y1;
    x2 = fr.x2;
    y2 = fr.y2;
    n = 0;
    for (int g = 0; g < tgd_pkg::NUM_GEST; g++) pend_on[g] = 1'b0;
    both = fr.f && fr.s;

    // one-finger gestures, including the release path while two fingers stay down
    if (fr.f && !two_down) begin
      if (!had_first) begin
        one_ms = 0;
        anchor[0] = x1;
        anchor[1] = y1;
      end
      if (held[tgd_pkg::G_SWIPE]) begin
        pend[tgd_pkg::G_SWIPE] = mk_ev(tgd_pkg::EV_REPEAT, x1, y1, 0, 0, one_ms);
        pend_on[tgd_pkg::G_SWIPE] = 1'b1;
      end else if (anchor[0] != x1 || anchor[1] != y1) begin
        pend[tgd_pkg::G_SWIPE] = mk_ev(tgd_pkg::EV_PRESSED, anchor[0], anchor[1], 0, 0,
                                       one_ms);
        pend_on[tgd_pkg::G_SWIPE] = 1'b1;
      end
      t_sum = one_ms + fr.el;
      if (t_sum > cfg_hold_time && one_ms <= cfg_hold_time && !held[tgd_pkg::G_SWIPE]) begin
        pend[tgd_pkg::G_HOLD] = mk_ev(tgd_pkg::EV_PRESSED, anchor[0], anchor[1], 0, 0,
                                      one_ms);
        pend_on[tgd_pkg::G_HOLD] = 1'b1;
      end
      one_ms = sat_time(t_sum);
    end else if (had_first) begin
      if (one_ms < cfg_hold_time) begin
        pend[tgd_pkg::G_TAP] = mk_ev(tgd_pkg::EV_PRESSED, anchor[0], anchor[1], 0, 0, one_ms);
        pend_on[tgd_pkg::G_TAP] = 1'b1;
      end else if (held[tgd_pkg::G_HOLD]) begin
        pend[tgd_pkg::G_HOLD] = mk_ev(tgd_pkg::EV_RELEASED, anchor[0], anchor[1], 0, 0,
                                      one_ms);
        pend_on[tgd_pkg::G_HOLD] = 1'b1;
      end
      if (held[tgd_pkg::G_SWIPE]) begin
        pend[tgd_pkg::G_SWIPE] = mk_ev(tgd_pkg::EV_RELEASED, x1, y1, 0, 0, one_ms);
        pend_on[tgd_pkg::G_SWIPE] = 1'b1;
      end
    end

    // two-finger gestures; a new two-finger touch takes over the shared anchor
    two_down = both;
    if (both) begin
      sw_lim = longint'(cfg_max_swipe) * cfg_max_swipe;
      pd_lim = longint'(cfg_pinch_dist) * cfg_pinch_dist;
      mv_lim = 4 * longint'(cfg_pinch_move) * cfg_pinch_move;
      if (!had_both) begin
        anchor[0] = x1;
        anchor[1] = y1;
        anchor[2] = x2;
        anchor[3] = y2;
        two_ms = 0;
        peak_change = 0;
        if (sq_dist(x1, y1, x2, y2) < sw_lim) begin
          pend[tgd_pkg::G_SWIPE2] = mk_ev(tgd_pkg::EV_PRESSED, x1, y1, x2, y2, 0);
          pend_on[tgd_pkg::G_SWIPE2] = 1'b1;
        end
        pend[tgd_pkg::G_PINCH] = mk_ev(tgd_pkg::EV_PRESSED, x1, y1, x2, y2, 0);
        pend_on[tgd_pkg::G_PINCH] = 1'b1;
      end
      // midpoint shift in doubled coordinates
      mdx = abs_diff(x1 + x2, anchor[0] + anchor[2]);
      mdy = abs_diff(y1 + y2, anchor[1] + anchor[3]);
      mv2 = mdx * mdx + mdy * mdy;
      chg = abs_diff(sq_dist(x1, y1, x2, y2),
                     sq_dist(anchor[0], anchor[1], anchor[2], anchor[3]));
      if (chg > peak_change) peak_change = chg;
      if (held[tgd_pkg::G_SWIPE2]) begin
        if (mv2 < mv_lim && peak_change > pd_lim) begin
          pend[tgd_pkg::G_SWIPE2] = mk_ev(tgd_pkg::EV_RELEASED, x1, y1, x2, y2, two_ms);
        end else begin
          pend[tgd_pkg::G_SWIPE2] = mk_ev(tgd_pkg::EV_REPEAT, x1, y1, x2, y2, two_ms);
        end
        pend_on[tgd_pkg::G_SWIPE2] = 1'b1;
      end
      if (held[tgd_pkg::G_PINCH]) begin
        if (mv2 > mv_lim && peak_change < pd_lim) begin
          pend[tgd_pkg::G_PINCH] = mk_ev(tgd_pkg::EV_RELEASED, x1, y1, x2, y2, two_ms);
        end else begin
          pend[tgd_pkg::G_PINCH] = mk_ev(tgd_pkg::EV_REPEAT, x1, y1, x2, y2, two_ms);
        end
        pend_on[tgd_pkg::G_PINCH] = 1'b1;
      end
      two_ms = sat_time(two_ms + fr.el);
    end else if (had_both) begin
      if (held[tgd_pkg::G_SWIPE2]) begin
        pend[tgd_pkg::G_SWIPE2] = mk_ev(tgd_pkg::EV_RELEASED, x1, y1, x2, y2, two_ms);
        pend_on[tgd_pkg::G_SWIPE2] = 1'b1;
      end
      if (held[tgd_pkg::G_PINCH]) begin
        pend[tgd_pkg::G_PINCH] = mk_ev(tgd_pkg::EV_RELEASED, x1, y1, x2, y2, two_ms);
        pend_on[tgd_pkg::G_PINCH] = 1'b1;
      end
    end

    had_first = fr.f;
    had_both  = both;

    // emit in gesture order; held flags follow what is actually sent
    for (int g = 0; g < tgd_pkg::NUM_GEST; g++) begin
      if (pend_on[g] && n < 4) begin
        outs[n] = pend[g];
        outs[n].gesture = tgd_pkg::gest_e'(g);
        n++;
        if (pend[g].kind == tgd_pkg::EV_PRESSED) held[g] = 1'b1;
        else if (pend[g].kind == tgd_pkg::EV_RELEASED) held[g] = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      due_events.push_back(outs[i]);
    end
  endfunction

  function automatic int rand_el();
    case ($urandom_range(0, 3))
      0: begin
        return $urandom_range(0, 15);
      end
      1: begin
        return $urandom_range(0, 1023);
      end
      default: begin
        return $urandom_range(20, 180);
      end
    endcase
  endfunction

  function automatic logic [CW-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > (1 << CW) - 1) return '1;
    return CW'(v);
  endfunction

  task automatic push_frame(bit f, bit s, int x1, int y1, int x2, int y2, int el);
    frame_t fr;
    fr.f  = f;
    fr.s  = s;
    fr.x1 = clip(x1);
    fr.y1 = clip(y1);
    fr.x2 = clip(x2);
    fr.y2 = clip(y2);
    fr.el = (el > 1023) ? 10'd1023 : tgd_pkg::ELAPSED_W'(el);
    frames_to_send.push_back(fr);
    n_pushed++;
  endtask

  // tap, hold or swipe with one finger, then a lift
  task automatic one_finger_seq();
    int px;
    int py;
    int len;
    int style;
    px = $urandom_range(0, 4095);
    py = $urandom_range(0, 4095);
    len = $urandom_range(1, 8);
    style = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && style == 1) begin
        px += $urandom_range(0, 40) - 20;
        py += $urandom_range(0, 40) - 20;
      end else if (i > 0 && style == 2) begin
        px += $urandom_range(0, 600) - 300;
        py += $urandom_range(0, 600) - 300;
      end
      push_frame(1'b1, ($urandom_range(0, 9) == 0), px, py,
                 $urandom_range(0, 4095), $urandom_range(0, 4095), rand_el());
    end
    push_frame(1'b0, ($urandom_range(0, 3) == 0), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
               rand_el());
  endtask

  // two-finger touch with translate, spread or jitter moves and one of three endings
  task automatic two_finger_seq();
    int x1;
    int y1;
    int x2;
    int y2;
    int dx;
    int dy;
    int len;
    x1 = $urandom_range(0, 4095);
    y1 = $urandom_range(0, 4095);
    if ($urandom_range(0, 1) == 1) begin
      x2 = x1 + $urandom_range(0, 300) - 150;
      y2 = y1 + $urandom_range(0, 300) - 150;
    end else begin
      x2 = $urandom_range(0, 4095);
      y2 = $urandom_range(0, 4095);
    end
    if ($urandom_range(0, 3) == 0) push_frame(1'b1, 1'b0, x1, y1, x2, y2, rand_el());
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        case ($urandom_range(0, 2))
          0: begin
            dx = $urandom_range(0, 200) - 100;
            dy = $urandom_range(0, 200) - 100;
            x1 += dx;
            x2 += dx;
            y1 += dy;
            y2 += dy;
          end
          1: begin
            dx = $urandom_range(0, 160) - 80;
            dy = $urandom_range(0, 160) - 80;
            x1 -= dx;
            x2 += dx;
            y1 -= dy;
            y2 += dy;
          end
          default: begin
            x1 += $urandom_range(0, 20) - 10;
            y1 += $urandom_range(0, 20) - 10;
            x2 += $urandom_range(0, 20) - 10;
            y2 += $urandom_range(0, 20) - 10;
          end
        endcase
      end
      push_frame(1'b1, 1'b1, x1, y1, x2, y2, rand_el());
    end
    case ($urandom_range(0, 2))
      0: begin
        push_frame(1'b0, 1'b0, x1, y1, x2, y2, rand_el());
      end
      1: begin
        push_frame(1'b1, 1'b0, x1, y1, x2, y2, rand_el());
        if ($urandom_range(0, 1) == 1) push_frame(1'b1, 1'b0, x1, y1, x2, y2, rand_el());
        push_frame(1'b0, 1'b0, x1, y1, x2, y2, rand_el());
      end
      default: begin
        push_frame(1'b0, 1'b1, x1, y1, x2, y2, rand_el());
        push_frame(1'b0, 1'b0, x1, y1, x2, y2, rand_el());
      end
    endcase
  endtask

  task automatic run_random(int target);
    int start;
    int pick;
    start = n_pushed;
    while (n_pushed - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        one_finger_seq();
      end else if (pick < 85) begin
        two_finger_seq();
      end else begin
        push_frame($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 1023));
      end
    end
  endtask

  // long press with near-maximum frame gaps, long enough to saturate the down-time
  task automatic soak(bit two);
    int x1;
    int y1;
    int x2;
    int y2;
    x1 = $urandom_range(0, 4095);
    y1 = $urandom_range(0, 4095);
    x2 = $urandom_range(0, 4095);
    y2 = $urandom_range(0, 4095);
    for (int i = 0; i < 67; i++) begin
      push_frame(1'b1, two, x1, y1, x2, y2, (i == 0) ? 0 : $urandom_range(1000, 1023));
    end
    push_frame(1'b0, 1'b0, x1, y1, x2, y2, $urandom_range(0, 1023));
  endtask

  task automatic apply_config(logic [tgd_pkg::HOLD_W-1:0] hold,
                              logic [tgd_pkg::DIST_CFG_W-1:0] swipe,
                              logic [tgd_pkg::DIST_CFG_W-1:0] pdist,
                              logic [tgd_pkg::DIST_CFG_W-1:0] pmove);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tgd_pkg::REG_HOLD_TIME;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_idx_i  <= tgd_pkg::REG_MAX_SWIPE;
    cfg_data_i <= {4'($urandom), swipe};
    @(posedge clk_i);
    cfg_idx_i  <= tgd_pkg::REG_PINCH_DIST;
    cfg_data_i <= {4'($urandom), pdist};
    @(posedge clk_i);
    cfg_idx_i  <= tgd_pkg::REG_PINCH_MOVE;
    cfg_data_i <= {4'($urandom), pmove};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_hold_time  = hold;
    cfg_max_swipe  = swipe;
    cfg_pinch_dist = pdist;
    cfg_pinch_move = pmove;
  endtask

  // frames can produce no event, so give the pipeline time to empty as well
  task automatic wait_idle();
    while (n_accepted != n_pushed || due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Frame driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_bus.valid <= 1'b0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        predict_gestures(offered);
        n_accepted++;
      end
      if (!frame_bus.valid || frame_bus.ready) begin
        if (src_wait == 0 && src_idle_on) begin
          if (src_run > 0) begin
            src_run--;
          end else if ($urandom_range(0, 3) == 0) begin
            src_wait = $urandom_range(1, 11);
            src_run  = $urandom_range(0, 24);
          end
        end
        if (src_wait > 0) begin
          src_wait--;
          frame_bus.valid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          offered = frames_to_send.pop_front();
          frame_bus.first_active  <= offered.f;
          frame_bus.second_active <= offered.s;
          frame_bus.first_x       <= offered.x1;
          frame_bus.first_y       <= offered.y1;
          frame_bus.second_x      <= offered.x2;
          frame_bus.second_y      <= offered.y2;
          frame_bus.elapsed_ms    <= offered.el;
          frame_bus.valid         <= 1'b1;
        end else begin
          frame_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_event();
    ev_t want;
    if (due_events.size() == 0) begin
      flag_error($sformatf("event with nothing pending: gesture %0d kind %0d",
                           event_bus.gesture, event_bus.event_kind));
      return;
    end
    want = due_events.pop_front();
    if (event_bus.gesture !== want.gesture)
      flag_error($sformatf("gesture %0d, want %0d", event_bus.gesture, want.gesture));
    if (event_bus.event_kind !== want.kind)
      flag_error($sformatf("gesture %0d kind %0d, want %0d", want.gesture,
                           event_bus.event_kind, want.kind));
    if (event_bus.pos_a_x !== want.ax || event_bus.pos_a_y !== want.ay)
      flag_error($sformatf("gesture %0d pos_a %0d,%0d, want %0d,%0d", want.gesture,
                           event_bus.pos_a_x, event_bus.pos_a_y, want.ax, want.ay));
    if (event_bus.pos_b_x !== want.bx || event_bus.pos_b_y !== want.by)
      flag_error($sformatf("gesture %0d pos_b %0d,%0d, want %0d,%0d", want.gesture,
                           event_bus.pos_b_x, event_bus.pos_b_y, want.bx, want.by));
    if (event_bus.down_ms !== want.down)
      flag_error($sformatf("gesture %0d down_ms %0d, want %0d", want.gesture,
                           event_bus.down_ms, want.down));
    if (event_bus.last !== want.last)
      flag_error($sformatf("gesture %0d last %0b, want %0b", want.gesture,
                           event_bus.last, want.last));
  endtask

  // Long receiver hold-off, counted down on its own
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left <= LONG_HOLD;
      hold_off_req = 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Event monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      event_bus.ready <= 1'b0;
    end else begin
      if (event_bus.valid && event_bus.ready) check_event();
      if (sink_wait == 0 && sink_idle_on) begin
        if (sink_run > 0) begin
          sink_run--;
        end else if ($urandom_range(0, 3) == 0) begin
          sink_wait = $urandom_range(1, 11);
          sink_run  = $urandom_range(0, 24);
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        event_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sequencer: reset, directed frames, then random phases under several settings
  initial begin
    int drain;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = tgd_pkg::REG_HOLD_TIME;
    cfg_data_i = '0;
    frame_bus.valid         = 1'b0;
    frame_bus.first_active  = 1'b0;
    frame_bus.second_active = 1'b0;
    frame_bus.first_x       = '0;
    frame_bus.first_y       = '0;
    frame_bus.second_x      = '0;
    frame_bus.second_y      = '0;
    frame_bus.elapsed_ms    = '0;
    event_bus.ready         = 1'b0;
    n_pushed = 0;
    n_accepted = 0;
    n_errors = 0;
    cycle_cnt = 0;
    src_wait = 0;
    src_run = 0;
    sink_wait = 0;
    sink_run = 0;
    hold_off_req = 1'b0;
    hold_left = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    cfg_hold_time  = tgd_pkg::HOLD_TIME_RST;
    cfg_max_swipe  = tgd_pkg::MAX_SWIPE_RST;
    cfg_pinch_dist = tgd_pkg::PINCH_DIST_RST;
    cfg_pinch_move = tgd_pkg::PINCH_MOVE_RST;
    had_first = 1'b0;
    had_both = 1'b0;
    two_down = 1'b0;
    for (int i = 0; i < 4; i++) anchor[i] = 0;
    one_ms = 0;
    two_ms = 0;
    peak_change = 0;
    for (int g = 0; g < tgd_pkg::NUM_GEST; g++) held[g] = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: tap, hold press and release, swipe, two-finger swipe and pinch
    push_frame(1'b1, 1'b0, 0, 0, 0, 0, 0);
    push_frame(1'b1, 1'b0, 0, 0, 0, 0, 100);
    push_frame(1'b0, 1'b0, 4095, 4095, 4095, 4095, 1023);       // tap
    push_frame(1'b1, 1'b0, 4095, 4095, 4095, 4095, 1023);       // hold pressed
    push_frame(1'b1, 1'b0, 4095, 4095, 4095, 4095, 0);
    push_frame(1'b0, 1'b0, 4095, 4095, 0, 0, 0);                // hold released
    push_frame(1'b1, 1'b0, 100, 200, 0, 0, 10);
    push_frame(1'b1, 1'b0, 300, 200, 0, 0, 10);                 // swipe pressed
    push_frame(1'b1, 1'b0, 400, 250, 0, 0, 10);                 // swipe repeat
    push_frame(1'b0, 1'b0, 500, 260, 0, 0, 10);                 // tap and swipe release
    push_frame(1'b1, 1'b1, 1000, 1000, 1050, 1000, 5);          // close pair
    push_frame(1'b1, 1'b1, 1100, 1000, 1150, 1000, 5);          // translate: pinch ends
    push_frame(1'b1, 1'b1, 875, 1000, 1175, 1000, 5);           // spread: swipe2 ends
    push_frame(1'b1, 1'b0, 875, 1000, 1175, 1000, 7);           // second finger lifts
    push_frame(1'b0, 1'b0, 0, 0, 0, 0, 0);
    push_frame(1'b1, 1'b1, 0, 0, 4095, 4095, 1023);             // wide pair, pinch only
    push_frame(1'b1, 1'b1, 0, 0, 4095, 4095, 1023);
    push_frame(1'b0, 1'b0, 0, 0, 4095, 4095, 1023);
    push_frame(1'b0, 1'b1, 12, 34, 56, 78, 9);                  // second finger alone
    push_frame(1'b1, 1'b0, 7, 7, 0, 0, 300);                    // exactly at hold time
    push_frame(1'b1, 1'b0, 7, 7, 0, 0, 1);
    push_frame(1'b0, 1'b0, 7, 7, 0, 0, 0);
    wait_idle();

    // default thresholds, random idling, one long receiver hold-off
    run_random(60);
    hold_off_req = 1'b1;
    wait_idle();

    // extremes, one way
    apply_config(16'd0, 12'd4095, 12'd0, 12'd4095);
    run_random(25);
    wait_idle();

    // extremes the other way, with down-time saturation on both timers
    apply_config(16'hFFFF, 12'd0, 12'd4095, 12'd0);
    soak(1'b0);
    soak(1'b1);
    wait_idle();

    // mid-range settings, no idling to the end
    apply_config(tgd_pkg::HOLD_W'($urandom_range(50, 600)),
                 tgd_pkg::DIST_CFG_W'($urandom_range(20, 400)),
                 tgd_pkg::DIST_CFG_W'($urandom_range(20, 400)),
                 tgd_pkg::DIST_CFG_W'($urandom_range(20, 400)));
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_random(35);

    while (n_accepted != n_pushed) @(posedge clk_i);
    drain = 0;
    while (due_events.size() != 0 && drain < DRAIN_MAX) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (due_events.size() != 0)
      flag_error($sformatf("%0d events never arrived", due_events.size()));

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
